// ----- design/x86enc_pkg.sv -----
// ----------------------------------------------------------------------------
// x86enc_pkg
// Shared types, codes and encoding helpers for the x86-64 byte encoder.
// ----------------------------------------------------------------------------
package x86enc_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int OFFSET_BITS_MAX = 48;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAX_BYTES       = 10;
  localparam int IDX_W           = 4;

  // Request kinds.
  localparam logic [4:0] KIND_RR64    = 5'd0;
  localparam logic [4:0] KIND_RR32    = 5'd1;
  localparam logic [4:0] KIND_RR16    = 5'd2;
  localparam logic [4:0] KIND_RR8     = 5'd3;
  localparam logic [4:0] KIND_MOV64   = 5'd4;
  localparam logic [4:0] KIND_MOV32   = 5'd5;
  localparam logic [4:0] KIND_MOV16   = 5'd6;
  localparam logic [4:0] KIND_MOV8    = 5'd7;
  localparam logic [4:0] KIND_PUSH    = 5'd8;
  localparam logic [4:0] KIND_POP     = 5'd9;
  localparam logic [4:0] KIND_RET     = 5'd10;
  localparam logic [4:0] KIND_NOP     = 5'd11;
  localparam logic [4:0] KIND_JMP     = 5'd12;
  localparam logic [4:0] KIND_CALL    = 5'd13;
  localparam logic [4:0] KIND_JCC     = 5'd14;
  localparam logic [4:0] KIND_JMP_REG = 5'd15;
  localparam logic [4:0] KIND_CALL_REG = 5'd16;

  // Fixed encoding bytes.
  localparam logic [7:0] BYTE_OPSIZE  = 8'h66;
  localparam logic [7:0] BYTE_ESCAPE  = 8'h0F;
  localparam logic [7:0] BYTE_CALL    = 8'hE8;
  localparam logic [7:0] BYTE_JMP     = 8'hE9;
  localparam logic [7:0] BYTE_MOV_IMM = 8'hB8;
  localparam logic [7:0] BYTE_MOV_IMM8 = 8'hB0;
  localparam logic [7:0] BYTE_PUSH    = 8'h50;
  localparam logic [7:0] BYTE_POP     = 8'h58;
  localparam logic [7:0] BYTE_RET     = 8'hC3;
  localparam logic [7:0] BYTE_NOP     = 8'h90;
  localparam logic [7:0] BYTE_REX     = 8'h40;
  localparam logic [7:0] BYTE_JCC     = 8'h80;
  localparam logic [7:0] BYTE_GROUP5  = 8'hFF;
  localparam logic [7:0] BYTE_MOD_REG = 8'hC0;

  localparam logic [2:0] EXT_CALL = 3'd2;
  localparam logic [2:0] EXT_JMP  = 3'd4;

  // One classified instruction, ready for byte-by-byte emission.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [IDX_W-1:0]          last_idx;
    logic                      reloc;
    logic [IDX_W-1:0]          reloc_idx;
    logic [9:0]                label;
  } x86enc_desc_t;

  function automatic logic [7:0] rex_byte(input logic w, input logic r, input logic b);
    rex_byte = BYTE_REX | {4'b0, w, r, 1'b0, b};
  endfunction

  function automatic logic [7:0] modrm_byte(input logic [2:0] reg_f, input logic [2:0] rm_f);
    modrm_byte = BYTE_MOD_REG | {2'b00, reg_f, rm_f};
  endfunction

endpackage

// ----- design/x86enc_if.sv -----
// ----------------------------------------------------------------------------
// x86enc_if
// Valid/ready channels for instruction requests and emitted code bytes.
// ----------------------------------------------------------------------------
interface x86enc_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [7:0]  opcode;
  logic [3:0]  first_reg;
  logic [3:0]  second_reg;
  logic [63:0] immediate;
  logic [3:0]  condition;
  logic [9:0]  target_label;

  modport source (output valid, kind, opcode, first_reg, second_reg, immediate,
                  condition, target_label, input ready);
  modport sink (input valid, kind, opcode, first_reg, second_reg, immediate,
                condition, target_label, output ready);
endinterface

interface x86enc_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  code_byte;
  logic [23:0] byte_offset;
  logic        last_byte;
  logic        reloc_start;
  logic [9:0]  reloc_label;
  logic        overflowed;

  modport source (output valid, code_byte, byte_offset, last_byte, reloc_start,
                  reloc_label, overflowed, input ready);
  modport sink (input valid, code_byte, byte_offset, last_byte, reloc_start,
                reloc_label, overflowed, output ready);
endinterface

// ----- design/x86_64_instruction_byte_encoder.sv -----
// ----------------------------------------------------------------------------
// x86_64_instruction_byte_encoder
// Encodes one x86-64 instruction request into its bytes, one byte per item.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Item carried
//   -------  ---  ---------------------------------------------------------
//   req      in   kind, opcode, first_reg, second_reg, immediate, condition,
//                 target_label
//   emit     out  code_byte, byte_offset, last_byte, reloc_start,
//                 reloc_label, overflowed
//
// An instruction leaves as 1 to 10 bytes, one per item, through the single
// byte-wide output register of the back end. The front end takes a request
// in every cycle in which the descriptor queue has room, so requests are
// accepted while earlier bytes still wait on a stalled output. Requests
// with an unused kind are taken and produce nothing. A synchronous reset
// clears the queue, the byte position and the sticky wrap flag; a stall on
// emit simply holds the byte.
//
// Structure: the front classifies each request into a descriptor holding
// all of its bytes, the length and where a rel32 slot starts; the queue
// decouples it from the back end, which walks the descriptor and tags each
// byte with the running offset.
module x86_64_instruction_byte_encoder #(
  parameter int OFFSET_BITS = x86enc_pkg::OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = x86enc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  x86enc_req_if.sink    req,
  x86enc_byte_if.source emit
);

  logic                     q_push;
  logic                     q_full;
  logic                     q_pop;
  logic                     q_avail;
  x86enc_pkg::x86enc_desc_t push_desc;
  x86enc_pkg::x86enc_desc_t pop_desc;

  x86enc_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (push_desc)
  );

  x86enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_desc  (pop_desc)
  );

  x86enc_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_desc  (pop_desc),
    .q_pop   (q_pop),
    .emit    (emit)
  );

endmodule

// ----- design/x86enc_front.sv -----
// ----------------------------------------------------------------------------
// x86enc_front
// Accepts requests and turns each into a byte descriptor for the queue.
// ----------------------------------------------------------------------------
module x86enc_front (
  x86enc_req_if.sink            req,
  input  logic                  q_full,
  output logic                  q_push,
  output x86enc_pkg::x86enc_desc_t q_desc
);

  logic                     known;
  logic                     b_ext;
  logic                     r_ext;
  logic [2:0]               rm;
  logic [7:0]               opc_eff;
  x86enc_pkg::x86enc_desc_t desc;

  assign b_ext   = req.first_reg[3];
  assign r_ext   = req.second_reg[3];
  assign rm      = req.first_reg[2:0];
  assign opc_eff = (req.kind == x86enc_pkg::KIND_RR8) ? req.opcode - 8'd1 : req.opcode;

  always_comb begin
    desc           = '0;
    desc.label     = req.target_label;
    known          = 1'b1;
    unique case (req.kind)
      x86enc_pkg::KIND_RR64, x86enc_pkg::KIND_RR32, x86enc_pkg::KIND_RR8: begin
        desc.bytes[0] = x86enc_pkg::rex_byte(req.kind == x86enc_pkg::KIND_RR64, r_ext, b_ext);
        desc.bytes[1] = opc_eff;
        desc.bytes[2] = x86enc_pkg::modrm_byte(req.second_reg[2:0], rm);
        desc.last_idx = 4'd2;
      end
      x86enc_pkg::KIND_RR16: begin
        desc.bytes[0] = x86enc_pkg::BYTE_OPSIZE;
        desc.bytes[1] = x86enc_pkg::rex_byte(1'b0, r_ext, b_ext);
        desc.bytes[2] = opc_eff;
        desc.bytes[3] = x86enc_pkg::modrm_byte(req.second_reg[2:0], rm);
        desc.last_idx = 4'd3;
      end
      x86enc_pkg::KIND_MOV64: begin
        desc.bytes[0] = x86enc_pkg::rex_byte(1'b1, 1'b0, b_ext);
        desc.bytes[1] = x86enc_pkg::BYTE_MOV_IMM + {5'b0, rm};
        for (int i = 0; i < 8; i++) begin
          desc.bytes[2+i] = req.immediate[8*i +: 8];
        end
        desc.last_idx = 4'd9;
      end
      x86enc_pkg::KIND_MOV32: begin
        desc.bytes[0] = x86enc_pkg::rex_byte(1'b0, 1'b0, b_ext);
        desc.bytes[1] = x86enc_pkg::BYTE_MOV_IMM + {5'b0, rm};
        for (int i = 0; i < 4; i++) begin
          desc.bytes[2+i] = req.immediate[8*i +: 8];
        end
        desc.last_idx = 4'd5;
      end
      x86enc_pkg::KIND_MOV16: begin
        desc.bytes[0] = x86enc_pkg::BYTE_OPSIZE;
        desc.bytes[1] = x86enc_pkg::rex_byte(1'b0, 1'b0, b_ext);
        desc.bytes[2] = x86enc_pkg::BYTE_MOV_IMM + {5'b0, rm};
        desc.bytes[3] = req.immediate[7:0];
        desc.bytes[4] = req.immediate[15:8];
        desc.last_idx = 4'd4;
      end
      x86enc_pkg::KIND_MOV8: begin
        desc.bytes[0] = x86enc_pkg::rex_byte(1'b0, 1'b0, b_ext);
        desc.bytes[1] = x86enc_pkg::BYTE_MOV_IMM8 + {5'b0, rm};
        desc.bytes[2] = req.immediate[7:0];
        desc.last_idx = 4'd2;
      end
      x86enc_pkg::KIND_PUSH, x86enc_pkg::KIND_POP: begin
        desc.bytes[0] = x86enc_pkg::rex_byte(1'b0, 1'b0, b_ext);
        desc.bytes[1] = ((req.kind == x86enc_pkg::KIND_PUSH) ? x86enc_pkg::BYTE_PUSH
                                                             : x86enc_pkg::BYTE_POP)
                        + {5'b0, rm};
        desc.last_idx = 4'd1;
      end
      x86enc_pkg::KIND_RET: begin
        desc.bytes[0] = x86enc_pkg::BYTE_RET;
        desc.last_idx = 4'd0;
      end
      x86enc_pkg::KIND_NOP: begin
        desc.bytes[0] = x86enc_pkg::BYTE_NOP;
        desc.last_idx = 4'd0;
      end
      x86enc_pkg::KIND_JMP, x86enc_pkg::KIND_CALL: begin
        desc.bytes[0]  = (req.kind == x86enc_pkg::KIND_CALL) ? x86enc_pkg::BYTE_CALL
                                                             : x86enc_pkg::BYTE_JMP;
        desc.reloc     = 1'b1;
        desc.reloc_idx = 4'd1;
        desc.last_idx  = 4'd4;
      end
      x86enc_pkg::KIND_JCC: begin
        desc.bytes[0]  = x86enc_pkg::BYTE_ESCAPE;
        desc.bytes[1]  = x86enc_pkg::BYTE_JCC + {4'b0, req.condition};
        desc.reloc     = 1'b1;
        desc.reloc_idx = 4'd2;
        desc.last_idx  = 4'd5;
      end
      x86enc_pkg::KIND_JMP_REG, x86enc_pkg::KIND_CALL_REG: begin
        desc.bytes[0] = x86enc_pkg::rex_byte(1'b1, 1'b0, b_ext);
        desc.bytes[1] = x86enc_pkg::BYTE_GROUP5;
        desc.bytes[2] = x86enc_pkg::modrm_byte(
                          (req.kind == x86enc_pkg::KIND_CALL_REG) ? x86enc_pkg::EXT_CALL
                                                                  : x86enc_pkg::EXT_JMP,
                          rm);
        desc.last_idx = 4'd2;
      end
      default: begin
        // Kinds without an encoding are consumed and produce no bytes.
        known = 1'b0;
      end
    endcase
  end

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full && known;
  assign q_desc    = desc;

endmodule

// ----- design/x86enc_queue.sv -----
// ----------------------------------------------------------------------------
// x86enc_queue
// Small descriptor FIFO between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module x86enc_queue #(
  parameter int DEPTH = x86enc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  x86enc_pkg::x86enc_desc_t push_desc,
  output logic                     full,
  input  logic                     pop,
  output logic                     avail,
  output x86enc_pkg::x86enc_desc_t pop_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  x86enc_pkg::x86enc_desc_t entries [DEPTH];
  logic [PTR_W-1:0]         wr_ptr;
  logic [PTR_W-1:0]         rd_ptr;
  logic [CNT_W-1:0]         count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign avail    = (count != '0);
  assign pop_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("descriptor pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail)
    else $error("descriptor popped from an empty queue");

endmodule

// ----- design/x86enc_back.sv -----
// ----------------------------------------------------------------------------
// x86enc_back
// Walks one descriptor at a time and emits its bytes with offset and flags.
// ----------------------------------------------------------------------------
module x86enc_back #(
  parameter int OFFSET_BITS = x86enc_pkg::OFFSET_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_avail,
  input  x86enc_pkg::x86enc_desc_t q_desc,
  output logic                     q_pop,
  x86enc_byte_if.source            emit
);

  x86enc_pkg::x86enc_desc_t        cur;
  logic                            cur_valid;
  logic [x86enc_pkg::IDX_W-1:0]    cur_idx;
  logic [OFFSET_BITS-1:0]          position;
  logic [OFFSET_BITS-1:0]          position_next;
  logic                            wrap_flag;
  logic                            out_valid;
  logic                            load;
  logic                            at_last;
  logic                            at_reloc;
  logic [x86enc_pkg::OFFSET_BITS_MAX-1:0] position_ext;

  assign load          = cur_valid && (!out_valid || emit.ready);
  assign at_last       = (cur_idx == cur.last_idx);
  assign at_reloc      = cur.reloc && (cur_idx == cur.reloc_idx);
  assign q_pop         = q_avail && (!cur_valid || (load && at_last));
  assign position_next = position + 1'b1;
  assign position_ext  = x86enc_pkg::OFFSET_BITS_MAX'(position);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_idx   <= '0;
      position  <= '0;
      wrap_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
        cur_idx   <= '0;
      end else if (load) begin
        if (at_last) begin
          cur_valid <= 1'b0;
        end
        cur_idx <= cur_idx + 1'b1;
      end
      if (load) begin
        position <= position_next;
        if (position_next == '0) begin
          wrap_flag <= 1'b1;
        end
        out_valid <= 1'b1;
      end else if (emit.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_desc;
    end
    if (load) begin
      emit.code_byte   <= cur.bytes[cur_idx];
      emit.byte_offset <= position_ext[23:0];
      emit.last_byte   <= at_last;
      emit.reloc_start <= at_reloc;
      emit.reloc_label <= at_reloc ? cur.label : 10'd0;
      emit.overflowed  <= wrap_flag;
    end
  end

  assign emit.valid = out_valid;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur_idx <= cur.last_idx)
    else $error("byte index ran past the end of the instruction");

  a_reloc_not_last: assert property (@(posedge clk) disable iff (rst)
    (emit.valid && emit.reloc_start) |-> !emit.last_byte)
    else $error("relocation slot start marked as final byte");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the x86-64 instruction byte encoder.
// It drives instruction requests, predicts the exact byte stream with offsets,
// relocation marks and the sticky wrap flag, and checks every emitted item.
// ----------------------------------------------------------------------------
module tb;

  // The encoder runs with its default 24-bit offset counter.
  localparam int CLK_PERIOD = 10;
  localparam int IDLE_PCT = 37;
  localparam int RANDOM_ITEMS = 286;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 100;
  localparam int TIMEOUT_NS = 5_000_000;

  typedef logic [x86enc_pkg::MAX_BYTES-1:0][7:0] byte_seq_t;

  // One instruction request, as carried by the request channel.
  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  opcode;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [63:0] immediate;
    logic [3:0]  condition;
    logic [9:0]  target_label;
  } instr_t;

  // One emitted code byte, as carried by the emit channel.
  typedef struct packed {
    logic [7:0]  code_byte;
    logic [23:0] byte_offset;
    logic        last_byte;
    logic        reloc_start;
    logic [9:0]  reloc_label;
    logic        overflowed;
  } code_item_t;

  // A row of the directed table. When typed_len is not negative, the row
  // carries its bytes written out by hand, first byte in typed[31:24].
  typedef struct {
    instr_t      instr;
    int          typed_len;
    logic [31:0] typed;
  } stim_row_t;

  logic clk;
  logic rst;

  x86enc_req_if  req();
  x86enc_byte_if emit();

  x86_64_instruction_byte_encoder dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .emit(emit)
  );

  // Predictor state: the running byte position and the sticky wrap flag.
  logic [23:0] code_pos;
  logic        pos_wrapped;

  // Bytes that the encoder still owes, oldest first.
  code_item_t expected_code[$];
  stim_row_t  directed_rows[$];

  int errors;
  int idle_pct;
  int stall_left;
  bit hold_request;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Nothing in a healthy run comes near this bound; it only catches a hang.
  initial begin
    #(TIMEOUT_NS);
    $display("x86_64_instruction_byte_encoder regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  function automatic logic [7:0] rex_of(input logic w, input logic r, input logic b);
    return x86enc_pkg::BYTE_REX | {4'b0000, w, r, 1'b0, b};
  endfunction

  function automatic logic [7:0] modrm_of(input logic [2:0] reg_field,
                                          input logic [2:0] rm_field);
    return x86enc_pkg::BYTE_MOD_REG | {2'b00, reg_field, rm_field};
  endfunction

  // Works out the bytes of one instruction. Returns how many there are;
  // reloc_at is the index of the first byte of a rel32 slot, or -1.
  function automatic int encode_instr(input instr_t x, output byte_seq_t seq,
                                      output int reloc_at);
    int n;
    int imm_len;
    n = 0;
    seq = '0;
    reloc_at = -1;
    case (x.kind)
      x86enc_pkg::KIND_RR64, x86enc_pkg::KIND_RR32, x86enc_pkg::KIND_RR16,
      x86enc_pkg::KIND_RR8: begin
        if (x.kind == x86enc_pkg::KIND_RR16) begin
          seq[n] = x86enc_pkg::BYTE_OPSIZE;
          n++;
        end
        seq[n] = rex_of(x.kind == x86enc_pkg::KIND_RR64, x.second_reg[3], x.first_reg[3]);
        n++;
        // The 8-bit form uses the opcode one below the given one; 0 wraps to 0xFF.
        seq[n] = (x.kind == x86enc_pkg::KIND_RR8) ? x.opcode - 8'd1 : x.opcode;
        n++;
        seq[n] = modrm_of(x.second_reg[2:0], x.first_reg[2:0]);
        n++;
      end
      x86enc_pkg::KIND_MOV64, x86enc_pkg::KIND_MOV32, x86enc_pkg::KIND_MOV16,
      x86enc_pkg::KIND_MOV8: begin
        imm_len = (x.kind == x86enc_pkg::KIND_MOV64) ? 8 :
                  (x.kind == x86enc_pkg::KIND_MOV32) ? 4 :
                  (x.kind == x86enc_pkg::KIND_MOV16) ? 2 : 1;
        if (x.kind == x86enc_pkg::KIND_MOV16) begin
          seq[n] = x86enc_pkg::BYTE_OPSIZE;
          n++;
        end
        seq[n] = rex_of(x.kind == x86enc_pkg::KIND_MOV64, 1'b0, x.first_reg[3]);
        n++;
        seq[n] = ((x.kind == x86enc_pkg::KIND_MOV8) ? x86enc_pkg::BYTE_MOV_IMM8
                                                    : x86enc_pkg::BYTE_MOV_IMM) +
                 {5'b0, x.first_reg[2:0]};
        n++;
        // The immediate goes out little-endian, truncated to the move width.
        for (int i = 0; i < imm_len; i++) begin
          seq[n] = x.immediate[8*i +: 8];
          n++;
        end
      end
      x86enc_pkg::KIND_PUSH, x86enc_pkg::KIND_POP: begin
        seq[n] = rex_of(1'b0, 1'b0, x.first_reg[3]);
        n++;
        seq[n] = ((x.kind == x86enc_pkg::KIND_PUSH) ? x86enc_pkg::BYTE_PUSH
                                                    : x86enc_pkg::BYTE_POP) +
                 {5'b0, x.first_reg[2:0]};
        n++;
      end
      x86enc_pkg::KIND_RET: begin
        seq[n] = x86enc_pkg::BYTE_RET;
        n++;
      end
      x86enc_pkg::KIND_NOP: begin
        seq[n] = x86enc_pkg::BYTE_NOP;
        n++;
      end
      x86enc_pkg::KIND_JMP, x86enc_pkg::KIND_CALL, x86enc_pkg::KIND_JCC: begin
        if (x.kind == x86enc_pkg::KIND_JCC) begin
          seq[n] = x86enc_pkg::BYTE_ESCAPE;
          n++;
          seq[n] = x86enc_pkg::BYTE_JCC + {4'b0, x.condition};
          n++;
        end else begin
          seq[n] = (x.kind == x86enc_pkg::KIND_CALL) ? x86enc_pkg::BYTE_CALL
                                                     : x86enc_pkg::BYTE_JMP;
          n++;
        end
        // The rel32 slot is four zero bytes; the first carries the label.
        reloc_at = n;
        n += 4;
      end
      x86enc_pkg::KIND_JMP_REG, x86enc_pkg::KIND_CALL_REG: begin
        seq[n] = rex_of(1'b1, 1'b0, x.first_reg[3]);
        n++;
        seq[n] = x86enc_pkg::BYTE_GROUP5;
        n++;
        seq[n] = modrm_of((x.kind == x86enc_pkg::KIND_CALL_REG) ? x86enc_pkg::EXT_CALL
                                                                : x86enc_pkg::EXT_JMP,
                          x.first_reg[2:0]);
        n++;
      end
      default: begin
        // An unused kind is taken and produces nothing.
      end
    endcase
    return n;
  endfunction

  // Tags each byte with the running position and the wrap flag as they
  // stand when it is placed, and queues it for checking.
  task automatic place_bytes(input byte_seq_t seq, input int count, input int reloc_at,
                             input logic [9:0] tag);
    code_item_t item;
    for (int i = 0; i < count; i++) begin
      item.code_byte   = seq[i];
      item.byte_offset = code_pos;
      item.last_byte   = (i == count - 1);
      item.reloc_start = (i == reloc_at);
      item.reloc_label = (i == reloc_at) ? tag : 10'd0;
      item.overflowed  = pos_wrapped;
      expected_code.push_back(item);
      code_pos = code_pos + 24'd1;
      // The flag first shows on the byte placed at the wrapped position.
      if (code_pos == 24'd0) begin
        pos_wrapped = 1'b1;
      end
    end
  endtask

  function automatic stim_row_t row(input logic [4:0] kind, input logic [7:0] opcode,
                                    input logic [3:0] first_reg, input logic [3:0] second_reg,
                                    input logic [63:0] immediate, input logic [3:0] condition,
                                    input logic [9:0] tag, input int typed_len,
                                    input logic [31:0] typed);
    stim_row_t r;
    r.instr = '{kind, opcode, first_reg, second_reg, immediate, condition, tag};
    r.typed_len = typed_len;
    r.typed = typed;
    return r;
  endfunction

  function automatic instr_t random_instr();
    instr_t x;
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      x.kind = x86enc_pkg::KIND_MOV64;
    end else if (pick >= 92) begin
      x.kind = 5'($urandom_range(31, 17));
    end else begin
      x.kind = 5'($urandom_range(16, 0));
    end
    x.opcode       = 8'($urandom);
    x.first_reg    = 4'($urandom);
    x.second_reg   = 4'($urandom);
    x.immediate    = {$urandom, $urandom};
    x.condition    = 4'($urandom);
    x.target_label = 10'($urandom_range(1023, 0));
    return x;
  endfunction

  // Offers one request, with random idle cycles in front of it, and runs the
  // predictor at the edge that accepts it. Valid is left high afterwards, so
  // back-to-back requests need no second assignment in one time step.
  task automatic send_instr(input instr_t x, input int typed_len, input logic [31:0] typed);
    byte_seq_t seq;
    int count;
    int reloc_at;
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.kind         <= x.kind;
    req.opcode       <= x.opcode;
    req.first_reg    <= x.first_reg;
    req.second_reg   <= x.second_reg;
    req.immediate    <= x.immediate;
    req.condition    <= x.condition;
    req.target_label <= x.target_label;
    @(posedge clk);
    while (!req.ready) begin
      @(posedge clk);
    end
    if (typed_len >= 0) begin
      seq = '0;
      for (int i = 0; i < typed_len; i++) begin
        seq[i] = typed[31 - 8*i -: 8];
      end
      place_bytes(seq, typed_len, -1, 10'd0);
    end else begin
      count = encode_instr(x, seq, reloc_at);
      place_bytes(seq, count, reloc_at, x.target_label);
    end
  endtask

  task automatic check_code_item();
    code_item_t want;
    if (expected_code.size() == 0) begin
      report_mismatch("unexpected code_byte", 64'(emit.code_byte), 64'd0);
      return;
    end
    want = expected_code.pop_front();
    if (emit.code_byte !== want.code_byte)
      report_mismatch("code_byte", 64'(emit.code_byte), 64'(want.code_byte));
    if (emit.byte_offset !== want.byte_offset)
      report_mismatch("byte_offset", 64'(emit.byte_offset), 64'(want.byte_offset));
    if (emit.last_byte !== want.last_byte)
      report_mismatch("last_byte", 64'(emit.last_byte), 64'(want.last_byte));
    if (emit.reloc_start !== want.reloc_start)
      report_mismatch("reloc_start", 64'(emit.reloc_start), 64'(want.reloc_start));
    if (emit.reloc_label !== want.reloc_label)
      report_mismatch("reloc_label", 64'(emit.reloc_label), 64'(want.reloc_label));
    if (emit.overflowed !== want.overflowed)
      report_mismatch("overflowed", 64'(emit.overflowed), 64'(want.overflowed));
  endtask

  // Receiver: checks each accepted item and picks ready for the next cycle.
  // On request it holds ready low for a long stretch, counting the cycles
  // here, so that the descriptor queue fills and the request side stalls.
  initial begin
    emit.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && emit.valid && emit.ready) begin
        check_code_item();
      end
      if (stall_left == 0 && hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        emit.ready <= 1'b0;
      end else begin
        emit.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Stimulus: directed table, then a fixed number of random requests.
  initial begin
    instr_t x;
    int valid_sent;
    bit hold_done;
    bit pause_done;

    errors = 0;
    idle_pct = IDLE_PCT;
    stall_left = 0;
    hold_request = 1'b0;
    code_pos = '0;
    pos_wrapped = 1'b0;
    valid_sent = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;

    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.kind         <= '0;
    req.opcode       <= '0;
    req.first_reg    <= '0;
    req.second_reg   <= '0;
    req.immediate    <= '0;
    req.condition    <= '0;
    req.target_label <= '0;

    // Rows with a typed_len that is not negative have their bytes typed in; the
    // rest of the table goes through the predictor. Ignored fields carry junk.
    directed_rows.push_back(row(x86enc_pkg::KIND_RET, 8'hFF, 4'hF, 4'hF, '1, 4'hF, 10'h3FF,
                                1, 32'hC300_0000));
    directed_rows.push_back(row(x86enc_pkg::KIND_NOP, 8'h00, 4'h0, 4'h0, '0, 4'h0, 10'h000,
                                1, 32'h9000_0000));
    // Unused kinds are swallowed without a byte.
    directed_rows.push_back(row(5'd31, 8'hFF, 4'hF, 4'hF, '1, 4'hF, 10'h3FF, 0, '0));
    directed_rows.push_back(row(5'd17, 8'h00, 4'h0, 4'h0, '0, 4'h0, 10'h000, 0, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_RR64, 8'h89, 4'h0, 4'h0, '0, 4'h0, 10'h000,
                                3, 32'h4889_C000));
    directed_rows.push_back(row(x86enc_pkg::KIND_RR64, 8'hFF, 4'hF, 4'hF, '0, 4'h0, 10'h000,
                                3, 32'h4DFF_FF00));
    directed_rows.push_back(row(x86enc_pkg::KIND_RR32, 8'h01, 4'h8, 4'h3, '1, 4'h7, 10'h155,
                                -1, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_RR16, 8'h8B, 4'h5, 4'hC, '0, 4'h0, 10'h000,
                                -1, '0));
    // Opcode zero in the 8-bit form wraps to 0xFF.
    directed_rows.push_back(row(x86enc_pkg::KIND_RR8, 8'h00, 4'h0, 4'h0, '0, 4'h0, 10'h000,
                                3, 32'h40FF_C000));
    directed_rows.push_back(row(x86enc_pkg::KIND_RR8, 8'h89, 4'h9, 4'hA, '0, 4'h0, 10'h000,
                                -1, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_MOV64, 8'h00, 4'hF, 4'h0,
                                64'hFFFF_FFFF_FFFF_FFFF, 4'h0, 10'h000, -1, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_MOV64, 8'hFF, 4'h0, 4'hF, 64'h0, 4'hF,
                                10'h3FF, -1, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_MOV32, 8'h00, 4'h3, 4'h0,
                                64'h89AB_CDEF_0123_4567, 4'h0, 10'h000, -1, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_MOV16, 8'h00, 4'hC, 4'h0,
                                64'h0000_0000_0000_8001, 4'h0, 10'h000, -1, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_MOV8, 8'h00, 4'hF, 4'h0,
                                64'h0000_0000_0000_00FF, 4'h0, 10'h000, 3, 32'h41B7_FF00));
    directed_rows.push_back(row(x86enc_pkg::KIND_PUSH, 8'h00, 4'h0, 4'h0, '0, 4'h0, 10'h000,
                                2, 32'h4050_0000));
    directed_rows.push_back(row(x86enc_pkg::KIND_POP, 8'h00, 4'hF, 4'h0, '0, 4'h0, 10'h000,
                                2, 32'h415F_0000));
    directed_rows.push_back(row(x86enc_pkg::KIND_PUSH, 8'h00, 4'h9, 4'h0, '0, 4'h0, 10'h000,
                                -1, '0));
    // Rel32 forms at both ends of the label and condition ranges.
    directed_rows.push_back(row(x86enc_pkg::KIND_JMP, 8'h00, 4'h0, 4'h0, '0, 4'h0, 10'h000,
                                -1, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_CALL, 8'hFF, 4'hF, 4'hF, '1, 4'hF, 10'h3FF,
                                -1, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_JCC, 8'h00, 4'h0, 4'h0, '0, 4'h0, 10'h005,
                                -1, '0));
    directed_rows.push_back(row(x86enc_pkg::KIND_JCC, 8'h00, 4'h0, 4'h0, '0, 4'hF, 10'h3FF,
                                -1, '0));
    // Indirect forms ignore second_reg and force the group extension.
    directed_rows.push_back(row(x86enc_pkg::KIND_JMP_REG, 8'h00, 4'h0, 4'hF, '0, 4'h0,
                                10'h000, 3, 32'h48FF_E000));
    directed_rows.push_back(row(x86enc_pkg::KIND_CALL_REG, 8'h00, 4'hF, 4'hF, '0, 4'h0,
                                10'h000, 3, 32'h49FF_D700));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_instr(directed_rows[i].instr, directed_rows[i].typed_len, directed_rows[i].typed);
    end

    // Random part; every request counts, unused kinds included.
    while (valid_sent < RANDOM_ITEMS) begin
      idle_pct = (valid_sent >= 150 && valid_sent < 210) ? 0 : IDLE_PCT;
      if (valid_sent == 80 && !hold_done) begin
        hold_done = 1'b1;
        hold_request = 1'b1;
      end
      if (valid_sent == 240 && !pause_done) begin
        // The sender goes quiet until every owed byte has come out.
        pause_done = 1'b1;
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_code.size() != 0) begin
          @(posedge clk);
        end
      end
      x = random_instr();
      send_instr(x, -1, '0);
      valid_sent++;
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_code.size() != 0) begin
      @(posedge clk);
    end
    // A few more cycles catch any stray byte after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("x86_64_instruction_byte_encoder regression: pass");
    end else begin
      $display("x86_64_instruction_byte_encoder regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/x86enc_pkg.sv
design/x86enc_if.sv
design/x86enc_front.sv
design/x86enc_queue.sv
design/x86enc_back.sv
design/x86_64_instruction_byte_encoder.sv
sim/tb.sv
